// ===== hw/rtl/ellr_pkg.sv =====
// Shared widths, types and operation codes of the ellipse rasteriser.
`timescale 1ns / 1ps

package ellr_pkg;

	localparam int COORD_BITS    = 16;
	localparam int RAD_BITS      = COORD_BITS + 1;
	localparam int CUR_BITS      = COORD_BITS + 2;
	localparam int PT_BITS       = COORD_BITS + 2;
	localparam int TERM_BITS     = 3 * COORD_BITS + 6;
	localparam int MUL_A_BITS    = 2 * COORD_BITS + 3;
	localparam int MUL_B_BITS    = COORD_BITS + 3;
	localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * PT_BITS + 7) / 8) * 8;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef logic signed [TERM_BITS-1:0] term_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} unit_op_t;

	typedef struct packed {
		unit_op_t op;
		term_t    a;
		term_t    b;
	} unit_req_t;

endpackage

// ===== hw/rtl/ellipse_rasterizer.sv =====
// Midpoint ellipse point generator, top level.
`timescale 1ns / 1ps

// A start item (tuser low) takes a centre and an edge point and prepares the terms of the
// midpoint loop, or prepares no terms when both radii are zero. Each advance item (tuser
// high) runs one loop iteration and returns four mirrored points: it is accepted, its terms
// are updated, the first arc hands over to the second where it ends, and the four points are
// loaded, each when the result stream can take it. Every term update and every multiply
// goes through one shared 54-bit unit, one operation per cycle. The final point of the
// ellipse carries tlast. An advance with no ellipse in progress is taken and gives nothing.
module ellipse_rasterizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// center_x, center_y, edge_x, edge_y
	input  logic [ellr_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// func
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// point_x, point_y, zero padding
	output logic [ellr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// arc_region
	output logic                                 m_tuser,
	output logic                                 m_tlast
);

	localparam int C  = ellr_pkg::COORD_BITS;
	localparam int TB = ellr_pkg::TERM_BITS;

	typedef enum logic [18:0] {
		ST_IDLE = 19'b1,
		ST_M1   = 19'b1 << 1,
		ST_M2   = 19'b1 << 2,
		ST_M3   = 19'b1 << 3,
		ST_M4   = 19'b1 << 4,
		ST_M5   = 19'b1 << 5,
		ST_E1   = 19'b1 << 6,
		ST_E2   = 19'b1 << 7,
		ST_E3   = 19'b1 << 8,
		ST_A1   = 19'b1 << 9,
		ST_A2   = 19'b1 << 10,
		ST_A3   = 19'b1 << 11,
		ST_A4   = 19'b1 << 12,
		ST_A5   = 19'b1 << 13,
		ST_A6   = 19'b1 << 14,
		ST_A7   = 19'b1 << 15,
		ST_A8   = 19'b1 << 16,
		ST_A9   = 19'b1 << 17,
		ST_EMIT = 19'b1 << 18
	} state_t;

	state_t st_q, st_d;
	logic   act_q, arc2_q;
	logic [1:0] k_q;
	logic   m_valid_q;

	logic signed [C-1:0]                       mid_x_q, mid_y_q;
	logic [ellr_pkg::RAD_BITS-1:0]             rx_q, ry_q;
	logic signed [ellr_pkg::CUR_BITS-1:0]      cur_x_q, cur_y_q, pbx_q, pby_q;
	ellr_pkg::term_t stop_x_q, stop_y_q, xch_q, ych_q, err_q, trx_q, try_q;
	logic   region_q, last_q;
	logic signed [ellr_pkg::PT_BITS-1:0]       m_px_q, m_py_q;
	logic   m_reg_q, m_last_q;

	logic signed [C-1:0]                       in_cx, in_cy, in_ex, in_ey;
	logic signed [ellr_pkg::RAD_BITS-1:0]      dx, dy;
	logic [ellr_pkg::RAD_BITS-1:0]             rx_new, ry_new;
	logic   in_acc, out_load, res_pos, res_neg;
	ellr_pkg::term_t   res, rx_t, ry_t, s_a, s_b, t_a, t_b, c_a, c_b;
	ellr_pkg::unit_req_t req;
	logic signed [ellr_pkg::PT_BITS-1:0]       mx_e, my_e, pt_x, pt_y;

	ellr_unit u_unit (
		.clk   (clk),
		.req   (req),
		.res_q (res)
	);

	always_comb begin
		in_cx  = s_tdata[C-1:0];
		in_cy  = s_tdata[2*C-1:C];
		in_ex  = s_tdata[3*C-1:2*C];
		in_ey  = s_tdata[4*C-1:3*C];
		dx     = ellr_pkg::RAD_BITS'(in_cx) - ellr_pkg::RAD_BITS'(in_ex);
		dy     = ellr_pkg::RAD_BITS'(in_cy) - ellr_pkg::RAD_BITS'(in_ey);
		rx_new = dx[ellr_pkg::RAD_BITS-1] ? -dx : dx;
		ry_new = dy[ellr_pkg::RAD_BITS-1] ? -dy : dy;
		in_acc = s_tvalid && s_tready;
		rx_t   = TB'(rx_q);
		ry_t   = TB'(ry_q);
		s_a    = arc2_q ? stop_x_q : stop_y_q;
		t_a    = arc2_q ? try_q : trx_q;
		c_a    = arc2_q ? xch_q : ych_q;
		s_b    = arc2_q ? stop_y_q : stop_x_q;
		t_b    = arc2_q ? trx_q : try_q;
		c_b    = arc2_q ? ych_q : xch_q;
		res_pos = (res != '0) && !res[TB-1];
		res_neg = res[TB-1];
		out_load = (st_q == ST_EMIT) && (!m_valid_q || m_tready);
		mx_e   = ellr_pkg::PT_BITS'(mid_x_q);
		my_e   = ellr_pkg::PT_BITS'(mid_y_q);
		pt_x   = k_q[0] ? mx_e - pbx_q : mx_e + pbx_q;
		pt_y   = k_q[1] ? my_e - pby_q : my_e + pby_q;
	end

	always_comb begin
		st_d   = st_q;
		req.op = ellr_pkg::OP_ADD;
		req.a  = s_a;
		req.b  = t_a;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == ellr_pkg::FUNC_START) begin
						if (rx_new != '0 || ry_new != '0) begin
							st_d = ST_M1;
						end
					end else if (act_q) begin
						st_d = ST_A1;
					end
				end
			end
			ST_M1: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = rx_t;
				req.b  = rx_t;
				st_d   = ST_M2;
			end
			ST_M2: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = ry_t;
				req.b  = ry_t;
				st_d   = ST_M3;
			end
			ST_M3: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = res;
				req.b  = TB'(1) - (rx_t <<< 1);
				st_d   = ST_M4;
			end
			ST_M4: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = try_q;
				req.b  = rx_t;
				st_d   = ST_M5;
			end
			ST_M5: st_d = ST_IDLE;
			ST_E1: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = trx_q >>> 1;
				req.b  = TB'(1) - (ry_t <<< 1);
				st_d   = ST_E2;
			end
			ST_E2: begin
				req.op = ellr_pkg::OP_MUL;
				req.a  = trx_q;
				req.b  = ry_t;
				st_d   = ST_E3;
			end
			ST_E3: st_d = ST_EMIT;
			ST_A1: st_d = ST_A2;
			ST_A2: begin
				req.a = err_q;
				req.b = c_a;
				st_d  = ST_A3;
			end
			ST_A3: begin
				req.a = c_a;
				req.b = t_a;
				st_d  = ST_A4;
			end
			ST_A4: begin
				req.a = err_q <<< 1;
				req.b = c_b;
				st_d  = ST_A5;
			end
			ST_A5: begin
				req.op = ellr_pkg::OP_SUB;
				req.a  = s_b;
				if (res_pos) begin
					req.b = t_b;
					st_d  = ST_A6;
				end else begin
					req.b = s_a;
					st_d  = ST_A9;
				end
			end
			ST_A6: begin
				req.a = err_q;
				req.b = c_b;
				st_d  = ST_A7;
			end
			ST_A7: begin
				req.a = c_b;
				req.b = t_b;
				st_d  = ST_A8;
			end
			ST_A8: begin
				req.op = ellr_pkg::OP_SUB;
				req.a  = s_b;
				req.b  = s_a;
				st_d   = ST_A9;
			end
			ST_A9: st_d = (!arc2_q && res_neg) ? ST_E1 : ST_EMIT;
			ST_EMIT: begin
				if (out_load && k_q == 2'd3) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			act_q     <= 1'b0;
			arc2_q    <= 1'b0;
			k_q       <= 2'd0;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE && in_acc && s_tuser == ellr_pkg::FUNC_START) begin
				act_q  <= 1'b0;
				arc2_q <= 1'b0;
			end
			if (st_q == ST_M5) begin
				act_q <= 1'b1;
			end
			if (st_q == ST_E3) begin
				arc2_q <= 1'b1;
			end
			if (st_q == ST_A9 && arc2_q && res_neg) begin
				act_q <= 1'b0;
			end
			if (st_q == ST_IDLE) begin
				k_q <= 2'd0;
			end else if (out_load) begin
				k_q <= k_q + 2'd1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == ellr_pkg::FUNC_START) begin
						mid_x_q <= in_cx;
						mid_y_q <= in_cy;
						rx_q    <= rx_new;
						ry_q    <= ry_new;
					end else begin
						pbx_q    <= cur_x_q;
						pby_q    <= cur_y_q;
						region_q <= arc2_q;
						last_q   <= 1'b0;
					end
				end
			end
			ST_M2: begin
				trx_q <= res <<< 1;
				ych_q <= res;
			end
			ST_M3: try_q <= res <<< 1;
			ST_M4: xch_q <= res;
			ST_M5: begin
				stop_x_q <= res;
				stop_y_q <= '0;
				err_q    <= '0;
				cur_x_q  <= ellr_pkg::CUR_BITS'(rx_q);
				cur_y_q  <= '0;
			end
			ST_E2: ych_q <= res;
			ST_E3: begin
				stop_y_q <= res;
				stop_x_q <= '0;
				xch_q    <= try_q >>> 1;
				err_q    <= '0;
				cur_x_q  <= '0;
				cur_y_q  <= ellr_pkg::CUR_BITS'(ry_q);
			end
			ST_A1: begin
				if (arc2_q) begin
					cur_x_q <= cur_x_q + ellr_pkg::CUR_BITS'(1);
				end else begin
					cur_y_q <= cur_y_q + ellr_pkg::CUR_BITS'(1);
				end
			end
			ST_A2: begin
				if (arc2_q) begin
					stop_x_q <= res;
				end else begin
					stop_y_q <= res;
				end
			end
			ST_A3, ST_A7: err_q <= res;
			ST_A4: begin
				if (arc2_q) begin
					xch_q <= res;
				end else begin
					ych_q <= res;
				end
			end
			ST_A5: begin
				if (res_pos) begin
					if (arc2_q) begin
						cur_y_q <= cur_y_q - ellr_pkg::CUR_BITS'(1);
					end else begin
						cur_x_q <= cur_x_q - ellr_pkg::CUR_BITS'(1);
					end
				end
			end
			ST_A6: begin
				if (arc2_q) begin
					stop_y_q <= res;
				end else begin
					stop_x_q <= res;
				end
			end
			ST_A8: begin
				if (arc2_q) begin
					ych_q <= res;
				end else begin
					xch_q <= res;
				end
			end
			ST_A9: begin
				if (arc2_q) begin
					last_q <= res_neg;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_px_q   <= pt_x;
			m_py_q   <= pt_y;
			m_reg_q  <= region_q;
			m_last_q <= (k_q == 2'd3) && last_q;
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = ellr_pkg::OUT_DATA_BITS'({m_py_q, m_px_q});
	assign m_tuser  = m_reg_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== hw/rtl/ellr_unit.sv =====
// Shared arithmetic unit: one signed multiply, add or subtract per cycle, result registered.
`timescale 1ns / 1ps

module ellr_unit (
	input  logic                clk,
	input  ellr_pkg::unit_req_t req,
	output ellr_pkg::term_t     res_q
);

	logic signed [ellr_pkg::MUL_A_BITS-1:0]                      mul_a;
	logic signed [ellr_pkg::MUL_B_BITS-1:0]                      mul_b;
	logic signed [ellr_pkg::MUL_A_BITS+ellr_pkg::MUL_B_BITS-1:0] prod;
	ellr_pkg::term_t                                             res_d;

	always_comb begin
		mul_a = req.a[ellr_pkg::MUL_A_BITS-1:0];
		mul_b = req.b[ellr_pkg::MUL_B_BITS-1:0];
		prod  = mul_a * mul_b;
		case (req.op)
			ellr_pkg::OP_ADD: res_d = req.a + req.b;
			ellr_pkg::OP_SUB: res_d = req.a - req.b;
			ellr_pkg::OP_MUL: res_d = ellr_pkg::TERM_BITS'(prod);
			default:          res_d = req.a;
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

// ===== hw/rtl/ellr_checker.sv =====
// Port-level assertions for the ellipse rasteriser and their binding.
`timescale 1ns / 1ps

module ellr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [ellr_pkg::IN_DATA_BITS-1:0]  s_tdata,
	input logic                               s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [ellr_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic                               m_tuser,
	input logic                               m_tlast
);

	localparam int C = ellr_pkg::COORD_BITS;

	// A waiting result item holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
	else $error("result item changed while stalled");

	// Only the second arc can finish the ellipse.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
	else $error("last point flagged outside the second arc");

	// A start with a non-zero radius keeps the input side busy while the terms are set up.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ellr_pkg::FUNC_START
			&& (s_tdata[C-1:0] != s_tdata[3*C-1:2*C]
				|| s_tdata[2*C-1:C] != s_tdata[4*C-1:3*C]) |=> !s_tready)
	else $error("start item did not occupy the block");

endmodule

bind ellipse_rasterizer ellr_checker u_ellr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
